// ----- sv/gss_pkg.sv -----
// Shared types and constants of the golden section minimum search.
package gss_pkg;

	localparam int PT_W   = 24;
	localparam int VAL_W  = 32;
	localparam int TOL_W  = 23;
	localparam int ADDR_W = 3;

	// Golden ratio (sqrt(5) - 1) / 2 in Q0.32.
	localparam logic [31:0] RATIO_Q32 = 32'h9E37_79B9;

	localparam logic [TOL_W-1:0] TOL_RESET = 23'd5898;

	// Register index, taken from paddr[2].
	localparam logic [0:0] REG_TOLERANCE = 1'b0;

	// Positions of the four probe points within one step.
	localparam logic [1:0] PT_LEFT      = 2'd0;
	localparam logic [1:0] PT_LEFT_INT  = 2'd1;
	localparam logic [1:0] PT_RIGHT_INT = 2'd2;
	localparam logic [1:0] PT_RIGHT     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPAN,
		S_RMUL,
		S_RWB,
		S_CHECK,
		S_POINTS,
		S_ISSUE,
		S_DRAIN1,
		S_DRAIN2,
		S_UPDATE,
		S_FISSUE,
		S_FWAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       span;
		logic       ratio_mul;
		logic       ratio_wb;
		logic       check;
		logic       points;
		logic       issue;
		logic       issue_fin;
		logic [1:0] sel;
		logic       update;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic span_gt_tol;
		logic step_go;
	} stat_t;

endpackage

// ----- sv/golden_section_minimum_search.sv -----
// Top level of the golden section minimum search with its configuration register.
//
// This block takes an interval [interval_low, interval_high] in signed Q8.16
// and searches it for the minimum of f(x) = x*x - 4x + 1 by golden section.
// Every shrink step evaluates f at both ends and at two interior points on one
// shared multiplier, then keeps the sub-interval around the least value, the
// leftmost one on ties. The result item carries the best point, f at that point
// and a flag that is set when the search ran into the MAX_STEPS limit with the
// gap still above the tolerance. An interval no wider than the tolerance
// returns interval_low at once. One item is in work at a time: a search runs
// a setup, its shrink steps and a wind-down that evaluates f at the best
// point, and an item with no step skips the steps. The four evaluations of a
// step, issued one per cycle into the multiplier and its two stage pipeline,
// set the cost of a step. A finished result waits in an output register, so
// the next item is taken while it is still unread. The tolerance register sits
// at byte address 0 of the APB port, resets to 5898 and must only be written
// while no search is running.
module golden_section_minimum_search #(
	parameter int FRAC_BITS = 16,
	parameter int MAX_STEPS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [gss_pkg::PT_W-1:0]    interval_low,
	input  logic signed [gss_pkg::PT_W-1:0]    interval_high,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [gss_pkg::PT_W-1:0]    best_point,
	output logic signed [gss_pkg::VAL_W-1:0]   best_value,
	output logic                               step_limit_hit,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic        [gss_pkg::ADDR_W-1:0]  paddr,
	input  logic        [31:0]                 pwdata,
	output logic        [31:0]                 prdata,
	output logic                               pready
);

	gss_pkg::cmd_t  cmd;
	gss_pkg::stat_t st;

	logic [gss_pkg::TOL_W-1:0] tol_q;
	logic                      tol_sel;

	// The only register decodes on address bit 2; higher addresses read zero.
	assign pready  = 1'b1;
	assign tol_sel = (paddr[2:2] == gss_pkg::REG_TOLERANCE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= gss_pkg::TOL_RESET;
		end else if (psel && penable && pwrite && pready && tol_sel) begin
			tol_q <= pwdata[gss_pkg::TOL_W-1:0];
		end
	end

	assign prdata = tol_sel ? {(32 - gss_pkg::TOL_W)'(0), tol_q} : 32'd0;

	gss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	gss_datapath #(
		.FRAC_BITS (FRAC_BITS),
		.MAX_STEPS (MAX_STEPS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.tol            (tol_q),
		.interval_low   (interval_low),
		.interval_high  (interval_high),
		.best_point     (best_point),
		.best_value     (best_value),
		.step_limit_hit (step_limit_hit)
	);

endmodule

// ----- sv/gss_ctrl.sv -----
// Controller state machine of the golden section minimum search.
module gss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  gss_pkg::stat_t st,
	output gss_pkg::cmd_t  cmd
);

	gss_pkg::state_t state_q, state_d;
	logic [1:0]      k_q, k_d;
	logic            out_valid_q, out_valid_d;
	logic            out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != gss_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gss_pkg::S_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			k_q         <= k_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		cmd         = '0;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			gss_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = gss_pkg::S_SPAN;
				end
			end
			gss_pkg::S_SPAN: begin
				cmd.span = 1'b1;
				state_d  = st.span_gt_tol ? gss_pkg::S_RMUL : gss_pkg::S_FISSUE;
			end
			gss_pkg::S_RMUL: begin
				cmd.ratio_mul = 1'b1;
				state_d       = gss_pkg::S_RWB;
			end
			gss_pkg::S_RWB: begin
				cmd.ratio_wb = 1'b1;
				state_d      = gss_pkg::S_CHECK;
			end
			gss_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = st.step_go ? gss_pkg::S_POINTS : gss_pkg::S_FISSUE;
			end
			gss_pkg::S_POINTS: begin
				cmd.points = 1'b1;
				k_d        = '0;
				state_d    = gss_pkg::S_ISSUE;
			end
			gss_pkg::S_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.sel   = k_q;
				k_d       = k_q + 2'd1;
				if (k_q == gss_pkg::PT_RIGHT) begin
					state_d = gss_pkg::S_DRAIN1;
				end
			end
			gss_pkg::S_DRAIN1: begin
				state_d = gss_pkg::S_DRAIN2;
			end
			gss_pkg::S_DRAIN2: begin
				state_d = gss_pkg::S_UPDATE;
			end
			gss_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = gss_pkg::S_CHECK;
			end
			gss_pkg::S_FISSUE: begin
				cmd.issue_fin = 1'b1;
				state_d       = gss_pkg::S_FWAIT;
			end
			gss_pkg::S_FWAIT: begin
				state_d = gss_pkg::S_OUT;
			end
			gss_pkg::S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = gss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gss_pkg::S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken result");

	a_issue_starts_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gss_pkg::S_POINTS |=> k_q == gss_pkg::PT_LEFT)
		else $error("probe issue does not start at the left end");
`endif

endmodule

// ----- sv/gss_datapath.sv -----
// Datapath of the golden section minimum search: ends, gaps, shared multiplier, output register.
module gss_datapath #(
	parameter int FRAC_BITS = 16,
	parameter int MAX_STEPS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gss_pkg::cmd_t                     cmd,
	output gss_pkg::stat_t                    st,
	input  logic        [gss_pkg::TOL_W-1:0]  tol,
	input  logic signed [gss_pkg::PT_W-1:0]   interval_low,
	input  logic signed [gss_pkg::PT_W-1:0]   interval_high,
	output logic signed [gss_pkg::PT_W-1:0]   best_point,
	output logic signed [gss_pkg::VAL_W-1:0]  best_value,
	output logic                              step_limit_hit
);

	localparam int SCW = $clog2(MAX_STEPS + 1);
	localparam logic [48:0] SQ_RND = 49'(1) << (FRAC_BITS - 1);
	localparam logic signed [50:0] F_ONE = 51'sd1 <<< FRAC_BITS;
	localparam logic signed [50:0] V_MAX = 51'sd2147483647;
	localparam logic signed [50:0] V_MIN = -51'sd2147483648;
	localparam logic signed [25:0] P_MAX = 26'sd8388607;
	localparam logic signed [25:0] P_MIN = -26'sd8388608;

	logic signed [23:0] left_q, right_q, best_q, p1_q, p2_q;
	logic        [23:0] cur_q, next_q, small_q;
	logic        [SCW-1:0] step_q;
	logic               limit_q;
	logic signed [31:0] min_val_q;
	logic        [1:0]  min_idx_q;

	logic signed [57:0] prod_s1;
	logic signed [23:0] pt_s1;
	logic        [1:0]  idx_s1;
	logic               vld_s1;
	logic signed [31:0] val_s2;
	logic        [1:0]  idx_s2;
	logic               vld_s2;

	logic signed [23:0] out_point_q;
	logic signed [31:0] out_value_q;
	logic               out_limit_q;

	logic signed [24:0] span;
	logic        [23:0] tol_ext;
	logic signed [23:0] x_sel, pick_pt;
	logic signed [24:0] mul_a;
	logic signed [32:0] mul_b;
	logic        [56:0] rsum;
	logic signed [25:0] ps1, ps2;
	logic        [48:0] sq_rnd, sq;
	logic signed [50:0] v_full;
	logic signed [31:0] v_sat;
	logic               mul_en;

	function automatic logic signed [23:0] pt_at(input logic [1:0] i,
		input logic signed [23:0] a, input logic signed [23:0] b,
		input logic signed [23:0] c, input logic signed [23:0] d);
		logic signed [23:0] r;
		unique case (i)
			gss_pkg::PT_LEFT:      r = a;
			gss_pkg::PT_LEFT_INT:  r = b;
			gss_pkg::PT_RIGHT_INT: r = c;
			default:               r = d;
		endcase
		return r;
	endfunction

	function automatic logic signed [23:0] sat_pt(input logic signed [25:0] s);
		logic signed [23:0] r;
		if (s > P_MAX) begin
			r = P_MAX[23:0];
		end else if (s < P_MIN) begin
			r = P_MIN[23:0];
		end else begin
			r = s[23:0];
		end
		return r;
	endfunction

	assign tol_ext = {1'b0, tol};
	assign span    = 25'(right_q) - 25'(left_q);

	assign st.span_gt_tol = span > $signed({2'b00, tol});
	assign st.step_go     = (cur_q > tol_ext) && (step_q < SCW'(MAX_STEPS));

	assign pick_pt = pt_at(min_idx_q, left_q, p1_q, p2_q, right_q);
	assign x_sel   = cmd.issue_fin ? best_q : pt_at(cmd.sel, left_q, p1_q, p2_q, right_q);

	// One multiplier serves both the golden ratio product and the squares.
	always_comb begin
		if (cmd.ratio_mul) begin
			mul_a = $signed({1'b0, cur_q});
			mul_b = $signed({1'b0, gss_pkg::RATIO_Q32});
		end else begin
			mul_a = 25'(x_sel);
			mul_b = 33'(x_sel);
		end
	end

	assign mul_en = cmd.ratio_mul || cmd.issue || cmd.issue_fin;
	assign rsum   = {1'b0, prod_s1[55:0]} + 57'(32'h8000_0000);

	assign ps1 = 26'(left_q) + $signed({2'b00, small_q});
	assign ps2 = 26'(right_q) - $signed({2'b00, small_q});

	// f(x) = round(x*x) - 4x + 1, saturated to 32 bits.
	assign sq_rnd = {1'b0, prod_s1[47:0]} + SQ_RND;
	assign sq     = sq_rnd >> FRAC_BITS;
	assign v_full = $signed({2'b00, sq}) - (51'(pt_s1) <<< 2) + F_ONE;

	always_comb begin
		if (v_full > V_MAX) begin
			v_sat = V_MAX[31:0];
		end else if (v_full < V_MIN) begin
			v_sat = V_MIN[31:0];
		end else begin
			v_sat = v_full[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			step_q  <= '0;
			limit_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue || cmd.issue_fin;
			vld_s2 <= vld_s1;
			if (cmd.load) begin
				step_q  <= '0;
				limit_q <= 1'b0;
			end
			if (cmd.check) begin
				limit_q <= cur_q > tol_ext;
			end
			if (cmd.update) begin
				step_q <= step_q + SCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q  <= interval_low;
			right_q <= interval_high;
			best_q  <= interval_low;
		end
		if (cmd.span) begin
			cur_q  <= st.span_gt_tol ? span[23:0] : '0;
			next_q <= '0;
		end
		if (cmd.ratio_wb) begin
			next_q <= rsum[55:32];
		end
		if (cmd.check) begin
			small_q <= (cur_q >= next_q) ? (cur_q - next_q) : '0;
		end
		if (cmd.points) begin
			p1_q <= sat_pt(ps1);
			p2_q <= sat_pt(ps2);
		end
		if (cmd.update) begin
			best_q <= pick_pt;
			if (min_idx_q == gss_pkg::PT_LEFT || min_idx_q == gss_pkg::PT_LEFT_INT) begin
				right_q <= p2_q;
			end else begin
				left_q <= p1_q;
			end
			cur_q  <= next_q;
			next_q <= small_q;
		end
		if (mul_en) begin
			prod_s1 <= mul_a * mul_b;
			pt_s1   <= x_sel;
			idx_s1  <= cmd.issue_fin ? gss_pkg::PT_LEFT : cmd.sel;
		end
		if (vld_s1) begin
			val_s2 <= v_sat;
			idx_s2 <= idx_s1;
		end
		// Running minimum, first position wins on ties.
		if (vld_s2) begin
			if (idx_s2 == gss_pkg::PT_LEFT || val_s2 < min_val_q) begin
				min_val_q <= val_s2;
				min_idx_q <= idx_s2;
			end
		end
		if (cmd.out_load) begin
			out_point_q <= best_q;
			out_value_q <= val_s2;
			out_limit_q <= limit_q;
		end
	end

	assign best_point     = out_point_q;
	assign best_value     = out_value_q;
	assign step_limit_hit = out_limit_q;

`ifndef ASSERT_OFF
	a_pipe_empty_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (!vld_s1 && !vld_s2))
		else $error("interval updated while evaluations are in flight");

	a_next_below_cur: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.ratio_wb) |-> next_q <= cur_q)
		else $error("second gap exceeds the first gap");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= SCW'(MAX_STEPS))
		else $error("step count beyond the step limit");
`endif

endmodule
